### src/ptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ptd_pkg
// shared widths, codes and types of the point to triangle distance pipeline
// ============================================================================
package ptd_pkg;

    localparam int COORD_W    = 24;
    localparam int PARAM_BITS = 16;
    localparam int DIST_W     = 50;

    localparam int DIFF_W = COORD_W + 1;
    localparam int QW     = PARAM_BITS + 1;
    localparam int DW     = 54;
    localparam int HALF_W = DW / 2;
    localparam int PP_W   = 2 * HALF_W + 2;
    localparam int PW     = 2 * DW;

    localparam int PROD_W = QW + DIFF_W + 1;
    localparam int OFF_W  = PROD_W + 1;
    localparam int W_W    = OFF_W + 1;
    localparam int NEAR_W = OFF_W + 2;

    localparam int FRONT_LAT = 7;
    localparam int DIV_LAT   = PARAM_BITS + 2;
    localparam int BACK_LAT  = 7;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;
    localparam int GEO_DLY   = FRONT_LAT - 1 + DIV_LAT;

    localparam logic [QW-1:0] PARAM_ONE = QW'(1) << PARAM_BITS;

    localparam logic signed [OFF_W:0] OFF_HALF = (OFF_W + 1)'(1) << (PARAM_BITS - 1);
    localparam logic signed [NEAR_W-1:0] NEAR_MAX = NEAR_W'((2 ** (COORD_W - 1)) - 1);
    localparam logic signed [NEAR_W-1:0] NEAR_MIN = NEAR_W'(-(2 ** (COORD_W - 1)));

    localparam logic signed [PW-1:0] DIST_HALF = PW'(1) << (2 * PARAM_BITS - 1);
    localparam logic signed [PW-1:0] DIST_SAT  = (PW'(1) << DIST_W) - PW'(1);

    localparam logic [2:0] FEAT_V0  = 3'd0;
    localparam logic [2:0] FEAT_V1  = 3'd1;
    localparam logic [2:0] FEAT_V2  = 3'd2;
    localparam logic [2:0] FEAT_E01 = 3'd3;
    localparam logic [2:0] FEAT_E12 = 3'd4;
    localparam logic [2:0] FEAT_E20 = 3'd5;
    localparam logic [2:0] FEAT_IN  = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_S_EDGE,
        SEL_T_EDGE,
        SEL_S_COMP,
        SEL_T_COMP,
        SEL_INTERIOR
    } sel_t;

    typedef struct packed {
        diff_t  [2:0] d;
        diff_t  [2:0] e0;
        diff_t  [2:0] e1;
        coord_t [2:0] v0;
    } geo_t;

    typedef struct packed {
        sel_t       sel;
        logic [2:0] feat;
        logic       degen;
    } ctl_t;

endpackage
`default_nettype wire

### src/ptd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ptd_mul
// two stage signed multiplier built from four registered partial products
// ============================================================================
module ptd_mul
    import ptd_pkg::*;
(
    input  logic                 clk,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    output logic signed [PW-1:0] p
);

    logic signed [HALF_W:0]   a_lo, a_hi, b_lo, b_hi;
    logic signed [PP_W-1:0]   pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic signed [PP_W-1:0]   pp_ll_next, pp_lh_next, pp_hl_next, pp_hh_next;
    logic signed [PW-1:0]     p_reg, p_next;

    always_comb
    begin
        a_lo = $signed({1'b0, a[HALF_W-1:0]});
        a_hi = $signed({a[DW-1], a[DW-1:HALF_W]});
        b_lo = $signed({1'b0, b[HALF_W-1:0]});
        b_hi = $signed({b[DW-1], b[DW-1:HALF_W]});
        pp_ll_next = a_lo * b_lo;
        pp_lh_next = a_lo * b_hi;
        pp_hl_next = a_hi * b_lo;
        pp_hh_next = a_hi * b_hi;
    end

    always_comb
    begin
        p_next = PW'(pp_ll_reg)
               + (PW'(pp_lh_reg) <<< HALF_W)
               + (PW'(pp_hl_reg) <<< HALF_W)
               + (PW'(pp_hh_reg) <<< DW);
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
        pp_hh_reg <= pp_hh_next;
        p_reg     <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

### src/ptd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ptd_div
// pipelined restoring divider, one quotient bit per stage, rounded and
// saturated to [0, 1] in unsigned q1.PARAM_BITS
// ============================================================================
module ptd_div
    import ptd_pkg::*;
(
    input  logic                 clk,
    input  logic signed [PW-1:0] num,
    input  logic signed [PW-1:0] den,
    output logic [QW-1:0]        quo
);

    logic [PW-1:0] r_reg    [0:PARAM_BITS];
    logic [PW-1:0] den_reg  [0:PARAM_BITS];
    logic [QW-1:0] q_reg    [0:PARAM_BITS];
    logic          sat_reg  [0:PARAM_BITS];
    logic [QW-1:0] satq_reg [0:PARAM_BITS];
    logic [PW-1:0] r_next   [1:PARAM_BITS];
    logic [QW-1:0] q_next   [1:PARAM_BITS];
    logic [PW-1:0] r_fin;
    logic [QW-1:0] quo_reg, quo_next;

    // classify: non-positive gives zero, num at or above den gives one
    always_ff @(posedge clk)
    begin
        r_reg[0]    <= num;
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        sat_reg[0]  <= (num <= 0) || (num >= den);
        satq_reg[0] <= (num <= 0) ? '0 : PARAM_ONE;
    end

    for (genvar i = 1; i <= PARAM_BITS; i++)
    begin : g_step
        logic [PW-1:0] r_dbl;

        always_comb
        begin
            r_dbl = {r_reg[i-1][PW-2:0], 1'b0};
            if (r_dbl >= den_reg[i-1])
            begin
                r_next[i] = r_dbl - den_reg[i-1];
                q_next[i] = {q_reg[i-1][QW-2:0], 1'b1};
            end
            else
            begin
                r_next[i] = r_dbl;
                q_next[i] = {q_reg[i-1][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[i]    <= r_next[i];
            q_reg[i]    <= q_next[i];
            den_reg[i]  <= den_reg[i-1];
            sat_reg[i]  <= sat_reg[i-1];
            satq_reg[i] <= satq_reg[i-1];
        end
    end

    // round to nearest, ties up
    always_comb
    begin
        r_fin = {r_reg[PARAM_BITS][PW-2:0], 1'b0};
        if (sat_reg[PARAM_BITS])
            quo_next = satq_reg[PARAM_BITS];
        else
            quo_next = q_reg[PARAM_BITS] + QW'(r_fin >= den_reg[PARAM_BITS]);
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

### src/ptd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ptd_front
// edge vectors, dot products, exact region products and region choice;
// hands the divider operands and the result selection to later stages
// ============================================================================
module ptd_front
    import ptd_pkg::*;
(
    input  logic                 clk,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic signed [COORD_W-1:0] vert0_x,
    input  logic signed [COORD_W-1:0] vert0_y,
    input  logic signed [COORD_W-1:0] vert0_z,
    input  logic signed [COORD_W-1:0] vert1_x,
    input  logic signed [COORD_W-1:0] vert1_y,
    input  logic signed [COORD_W-1:0] vert1_z,
    input  logic signed [COORD_W-1:0] vert2_x,
    input  logic signed [COORD_W-1:0] vert2_y,
    input  logic signed [COORD_W-1:0] vert2_z,
    output geo_t                 geo,
    output ctl_t                 ctl,
    output logic signed [PW-1:0] num_a,
    output logic signed [PW-1:0] den_a,
    output logic signed [PW-1:0] num_b,
    output logic signed [PW-1:0] den_b
);

    typedef struct packed {
        logic signed [DW-1:0] den;
        logic signed [DW-1:0] nb0;
        logic signed [DW-1:0] nb1;
        logic signed [DW-1:0] xb0;
        logic signed [DW-1:0] xb1;
        logic signed [DW-1:0] u1;
        logic signed [DW-1:0] u2;
        logic signed [DW-1:0] a00;
        logic signed [DW-1:0] a11;
    } small_t;

    typedef struct packed {
        logic b0neg;
        logic b1neg;
        logic c0end;
        logic c1end;
        logic u1pos;
        logic u1ge;
        logic u2pos;
        logic u2ge;
    } flag_t;

    function automatic logic signed [DW-1:0] dot3(input diff_t [2:0] x, input diff_t [2:0] y);
        logic signed [2*DIFF_W-1:0] p0, p1, p2;
        p0 = $signed(x[0]) * $signed(y[0]);
        p1 = $signed(x[1]) * $signed(y[1]);
        p2 = $signed(x[2]) * $signed(y[2]);
        return DW'(p0) + DW'(p1) + DW'(p2);
    endfunction

    geo_t                 geo_reg, geo_next;
    logic signed [DW-1:0] a00_reg, a01_reg, a11_reg, b0_reg, b1_reg;
    small_t               sm_p3_reg, sm_p3_next, sm_p4_reg, sm_p5_reg, sm_p6_reg;
    logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
    logic signed [PW-1:0] det_raw_reg, sn_p5_reg, tn_p5_reg;
    logic signed [PW-1:0] det_abs_reg, sum_st_reg, sn_p6_reg, tn_p6_reg;
    logic signed [PW-1:0] det_abs_next;
    flag_t                fl_reg, fl_next;
    ctl_t                 ctl_reg, ctl_next;
    logic signed [PW-1:0] num_a_reg, den_a_reg, num_b_reg, den_b_reg;
    logic signed [PW-1:0] num_a_next, den_a_next, num_b_next, den_b_next;
    logic                 sn_neg, tn_neg, in_tri, det_zero;
    logic [2:0]           feat_e0, feat_e1;

    // stage 1: difference vectors
    always_comb
    begin
        geo_next.v0[0] = vert0_x;
        geo_next.v0[1] = vert0_y;
        geo_next.v0[2] = vert0_z;
        geo_next.d[0]  = DIFF_W'(vert0_x) - DIFF_W'(point_x);
        geo_next.d[1]  = DIFF_W'(vert0_y) - DIFF_W'(point_y);
        geo_next.d[2]  = DIFF_W'(vert0_z) - DIFF_W'(point_z);
        geo_next.e0[0] = DIFF_W'(vert1_x) - DIFF_W'(vert0_x);
        geo_next.e0[1] = DIFF_W'(vert1_y) - DIFF_W'(vert0_y);
        geo_next.e0[2] = DIFF_W'(vert1_z) - DIFF_W'(vert0_z);
        geo_next.e1[0] = DIFF_W'(vert2_x) - DIFF_W'(vert0_x);
        geo_next.e1[1] = DIFF_W'(vert2_y) - DIFF_W'(vert0_y);
        geo_next.e1[2] = DIFF_W'(vert2_z) - DIFF_W'(vert0_z);
    end

    always_ff @(posedge clk)
    begin
        geo_reg <= geo_next;
    end

    // stage 2: dot products
    always_ff @(posedge clk)
    begin
        a00_reg <= dot3(geo_reg.e0, geo_reg.e0);
        a01_reg <= dot3(geo_reg.e0, geo_reg.e1);
        a11_reg <= dot3(geo_reg.e1, geo_reg.e1);
        b0_reg  <= dot3(geo_reg.d, geo_reg.e0);
        b1_reg  <= dot3(geo_reg.d, geo_reg.e1);
    end

    // stages 3 and 4: wide products, small sums beside them
    ptd_mul u_mul0 (.clk(clk), .a(a00_reg), .b(a11_reg), .p(m0));
    ptd_mul u_mul1 (.clk(clk), .a(a01_reg), .b(a01_reg), .p(m1));
    ptd_mul u_mul2 (.clk(clk), .a(a01_reg), .b(b1_reg),  .p(m2));
    ptd_mul u_mul3 (.clk(clk), .a(a11_reg), .b(b0_reg),  .p(m3));
    ptd_mul u_mul4 (.clk(clk), .a(a01_reg), .b(b0_reg),  .p(m4));
    ptd_mul u_mul5 (.clk(clk), .a(a00_reg), .b(b1_reg),  .p(m5));

    always_comb
    begin
        sm_p3_next.den = a00_reg - (a01_reg <<< 1) + a11_reg;
        sm_p3_next.nb0 = -b0_reg;
        sm_p3_next.nb1 = -b1_reg;
        sm_p3_next.xb0 = a00_reg + b0_reg;
        sm_p3_next.xb1 = a11_reg + b1_reg;
        sm_p3_next.u1  = (a11_reg + b1_reg) - (a01_reg + b0_reg);
        sm_p3_next.u2  = (a00_reg + b0_reg) - (a01_reg + b1_reg);
        sm_p3_next.a00 = a00_reg;
        sm_p3_next.a11 = a11_reg;
    end

    always_ff @(posedge clk)
    begin
        sm_p3_reg <= sm_p3_next;
        sm_p4_reg <= sm_p3_reg;
    end

    // stage 5: determinant and unnormalized parameters
    always_ff @(posedge clk)
    begin
        det_raw_reg <= m0 - m1;
        sn_p5_reg   <= m2 - m3;
        tn_p5_reg   <= m4 - m5;
        sm_p5_reg   <= sm_p4_reg;
    end

    // stage 6: magnitude, sum and edge flags
    always_comb
    begin
        det_abs_next  = det_raw_reg[PW-1] ? -det_raw_reg : det_raw_reg;
        fl_next.b0neg = sm_p5_reg.nb0 > 0;
        fl_next.b1neg = sm_p5_reg.nb1 > 0;
        fl_next.c0end = sm_p5_reg.xb0 <= 0;
        fl_next.c1end = sm_p5_reg.xb1 <= 0;
        fl_next.u1pos = sm_p5_reg.u1 > 0;
        fl_next.u1ge  = sm_p5_reg.u1 >= sm_p5_reg.den;
        fl_next.u2pos = sm_p5_reg.u2 > 0;
        fl_next.u2ge  = sm_p5_reg.u2 >= sm_p5_reg.den;
    end

    always_ff @(posedge clk)
    begin
        det_abs_reg <= det_abs_next;
        sum_st_reg  <= sn_p5_reg + tn_p5_reg;
        sn_p6_reg   <= sn_p5_reg;
        tn_p6_reg   <= tn_p5_reg;
        sm_p6_reg   <= sm_p5_reg;
        fl_reg      <= fl_next;
    end

    // stage 7: region choice
    always_comb
    begin
        sn_neg   = sn_p6_reg[PW-1];
        tn_neg   = tn_p6_reg[PW-1];
        in_tri   = sum_st_reg <= det_abs_reg;
        det_zero = det_abs_reg == '0;
        feat_e0  = !fl_reg.b0neg ? FEAT_V0 : (fl_reg.c0end ? FEAT_V1 : FEAT_E01);
        feat_e1  = !fl_reg.b1neg ? FEAT_V0 : (fl_reg.c1end ? FEAT_V2 : FEAT_E20);

        ctl_next.sel   = SEL_ZERO;
        ctl_next.feat  = FEAT_V0;
        ctl_next.degen = 1'b0;
        num_a_next     = '0;
        den_a_next     = '0;
        num_b_next     = '0;
        den_b_next     = '0;

        if (in_tri)
        begin
            if (sn_neg && !(tn_neg && fl_reg.b0neg))
            begin
                ctl_next.sel  = SEL_T_EDGE;
                ctl_next.feat = feat_e1;
                num_a_next    = PW'(sm_p6_reg.nb1);
                den_a_next    = PW'(sm_p6_reg.a11);
            end
            else if (sn_neg || tn_neg)
            begin
                ctl_next.sel  = SEL_S_EDGE;
                ctl_next.feat = feat_e0;
                num_a_next    = PW'(sm_p6_reg.nb0);
                den_a_next    = PW'(sm_p6_reg.a00);
            end
            else if (det_zero)
            begin
                ctl_next.degen = 1'b1;
            end
            else
            begin
                ctl_next.sel  = SEL_INTERIOR;
                ctl_next.feat = FEAT_IN;
                num_a_next    = sn_p6_reg;
                den_a_next    = det_abs_reg;
                num_b_next    = tn_p6_reg;
                den_b_next    = det_abs_reg;
            end
        end
        else if (sn_neg)
        begin
            if (fl_reg.u1pos)
            begin
                ctl_next.sel  = SEL_S_COMP;
                ctl_next.feat = fl_reg.u1ge ? FEAT_V1 : FEAT_E12;
                num_a_next    = PW'(sm_p6_reg.u1);
                den_a_next    = PW'(sm_p6_reg.den);
            end
            else
            begin
                ctl_next.sel  = SEL_T_EDGE;
                ctl_next.feat = feat_e1;
                num_a_next    = PW'(sm_p6_reg.nb1);
                den_a_next    = PW'(sm_p6_reg.a11);
            end
        end
        else if (tn_neg)
        begin
            if (fl_reg.u2pos)
            begin
                ctl_next.sel  = SEL_T_COMP;
                ctl_next.feat = fl_reg.u2ge ? FEAT_V2 : FEAT_E12;
                num_a_next    = PW'(sm_p6_reg.u2);
                den_a_next    = PW'(sm_p6_reg.den);
            end
            else
            begin
                ctl_next.sel  = SEL_S_EDGE;
                ctl_next.feat = feat_e0;
                num_a_next    = PW'(sm_p6_reg.nb0);
                den_a_next    = PW'(sm_p6_reg.a00);
            end
        end
        else
        begin
            ctl_next.sel  = SEL_S_COMP;
            ctl_next.feat = !fl_reg.u1pos ? FEAT_V2 : (fl_reg.u1ge ? FEAT_V1 : FEAT_E12);
            num_a_next    = PW'(sm_p6_reg.u1);
            den_a_next    = PW'(sm_p6_reg.den);
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg   <= ctl_next;
        num_a_reg <= num_a_next;
        den_a_reg <= den_a_next;
        num_b_reg <= num_b_next;
        den_b_reg <= den_b_next;
    end

    assign geo   = geo_reg;
    assign ctl   = ctl_reg;
    assign num_a = num_a_reg;
    assign den_a = den_a_reg;
    assign num_b = num_b_reg;
    assign den_b = den_b_reg;

endmodule
`default_nettype wire

### src/ptd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ptd_back
// parameter selection, closest point and squared distance
// ============================================================================
module ptd_back
    import ptd_pkg::*;
(
    input  logic                      clk,
    input  geo_t                      geo,
    input  ctl_t                      ctl,
    input  logic [QW-1:0]             qa,
    input  logic [QW-1:0]             qb,
    output logic [DIST_W-1:0]         dist_sq,
    output logic signed [COORD_W-1:0] near_x,
    output logic signed [COORD_W-1:0] near_y,
    output logic signed [COORD_W-1:0] near_z,
    output logic [2:0]                feature,
    output logic [QW-1:0]             param_s,
    output logic [QW-1:0]             param_t,
    output logic                      degenerate
);

    typedef struct packed {
        ctl_t          ctl;
        logic [QW-1:0] s;
        logic [QW-1:0] t;
    } tag_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic signed [W_W-1:0]    wv_t;

    tag_t   tag1_reg, tag1_next, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    geo_t   geo1_reg, geo2_reg;
    prod_t  [2:0] ps_reg, pt_reg;
    off_t   [2:0] off_reg;
    wv_t    [2:0] w_reg;
    coord_t [2:0] v0_reg;
    coord_t [2:0] near4_reg, near4_next, near5_reg, near6_reg, near7_reg;
    logic signed [PW-1:0] sq [0:2];
    logic signed [PW-1:0] sq_sum_reg;
    logic signed [PW-1:0] dist_rnd;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    tag_t                 tag7_reg;

    // F1: parameters from the divider results
    always_comb
    begin
        tag1_next.ctl = ctl;
        case (ctl.sel)
            SEL_S_EDGE:
            begin
                tag1_next.s = qa;
                tag1_next.t = '0;
            end
            SEL_T_EDGE:
            begin
                tag1_next.s = '0;
                tag1_next.t = qa;
            end
            SEL_S_COMP:
            begin
                tag1_next.s = qa;
                tag1_next.t = PARAM_ONE - qa;
            end
            SEL_T_COMP:
            begin
                tag1_next.s = PARAM_ONE - qa;
                tag1_next.t = qa;
            end
            SEL_INTERIOR:
            begin
                tag1_next.s = qa;
                tag1_next.t = qb;
            end
            default:
            begin
                tag1_next.s = '0;
                tag1_next.t = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= tag1_next;
        geo1_reg <= geo;
    end

    // F2: weighted edges
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ps_reg[k] <= $signed({1'b0, tag1_reg.s}) * $signed(geo1_reg.e0[k]);
            pt_reg[k] <= $signed({1'b0, tag1_reg.t}) * $signed(geo1_reg.e1[k]);
        end
        tag2_reg <= tag1_reg;
        geo2_reg <= geo1_reg;
    end

    // F3: offset from vertex 0 and scaled separation
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            off_reg[k] <= OFF_W'(ps_reg[k]) + OFF_W'(pt_reg[k]);
            w_reg[k]   <= (W_W'($signed(geo2_reg.d[k])) <<< PARAM_BITS)
                        + W_W'(OFF_W'(ps_reg[k]) + OFF_W'(pt_reg[k]));
        end
        v0_reg   <= geo2_reg.v0;
        tag3_reg <= tag2_reg;
    end

    // F4: rounded, saturated closest point
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [OFF_W:0]    off_h;
            logic signed [NEAR_W-1:0] n_wide;
            off_h  = (OFF_W + 1)'(off_reg[k]) + OFF_HALF;
            n_wide = NEAR_W'($signed(v0_reg[k])) + NEAR_W'(off_h >>> PARAM_BITS);
            if (n_wide > NEAR_MAX)
                near4_next[k] = COORD_W'(NEAR_MAX);
            else if (n_wide < NEAR_MIN)
                near4_next[k] = COORD_W'(NEAR_MIN);
            else
                near4_next[k] = COORD_W'(n_wide);
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_sq
        ptd_mul u_sq (
            .clk(clk),
            .a  (DW'(w_reg[k])),
            .b  (DW'(w_reg[k])),
            .p  (sq[k])
        );
    end

    always_ff @(posedge clk)
    begin
        near4_reg <= near4_next;
        tag4_reg  <= tag3_reg;
        near5_reg <= near4_reg;
        tag5_reg  <= tag4_reg;
    end

    // F6: sum of squares
    always_ff @(posedge clk)
    begin
        sq_sum_reg <= sq[0] + sq[1] + sq[2];
        near6_reg  <= near5_reg;
        tag6_reg   <= tag5_reg;
    end

    // F7: round and saturate
    always_comb
    begin
        dist_rnd = (sq_sum_reg + DIST_HALF) >>> (2 * PARAM_BITS);
        if (dist_rnd < 0)
            dist_next = '0;
        else if (dist_rnd > DIST_SAT)
            dist_next = DIST_SAT[DIST_W-1:0];
        else
            dist_next = dist_rnd[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        near7_reg <= near6_reg;
        tag7_reg  <= tag6_reg;
    end

    assign dist_sq    = dist_reg;
    assign near_x     = near7_reg[0];
    assign near_y     = near7_reg[1];
    assign near_z     = near7_reg[2];
    assign feature    = tag7_reg.ctl.feat;
    assign param_s    = tag7_reg.s;
    assign param_t    = tag7_reg.t;
    assign degenerate = tag7_reg.ctl.degen;

endmodule
`default_nettype wire

### src/point_triangle_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// point_triangle_distance
// squared distance, closest point and closest feature of a point to a
// triangle, fixed point, fully pipelined
// ============================================================================
// usage
//   a query beat is taken on every rising edge with start high and busy low;
//   busy is held low, so a new query may enter on every cycle
//   each result beat is marked by done for exactly one cycle; results
//   leave in query order
//   throughput: one query per clock, set by the fully registered datapath
//   pipeline: dot products, exact region products and region choice,
//   then the bit per stage divider (two run side by side), then
//   parameter selection, closest point and distance
//   the receiver cannot hold a result off; none is needed as nothing stalls
//   reset clears only the valid bits: no done strobe follows reset until a
//   new query arrives
//   a zero determinant yields vertex 0 with the degenerate flag set
// ============================================================================
module point_triangle_distance
    import ptd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic signed [COORD_W-1:0] vert0_x,
    input  logic signed [COORD_W-1:0] vert0_y,
    input  logic signed [COORD_W-1:0] vert0_z,
    input  logic signed [COORD_W-1:0] vert1_x,
    input  logic signed [COORD_W-1:0] vert1_y,
    input  logic signed [COORD_W-1:0] vert1_z,
    input  logic signed [COORD_W-1:0] vert2_x,
    input  logic signed [COORD_W-1:0] vert2_y,
    input  logic signed [COORD_W-1:0] vert2_z,
    output logic                      done,
    output logic [DIST_W-1:0]         dist_sq,
    output logic signed [COORD_W-1:0] near_x,
    output logic signed [COORD_W-1:0] near_y,
    output logic signed [COORD_W-1:0] near_z,
    output logic [2:0]                feature,
    output logic [QW-1:0]             param_s,
    output logic [QW-1:0]             param_t,
    output logic                      degenerate
);

    logic [TOTAL_LAT-1:0] valid_reg, valid_next;
    geo_t                 geo;
    ctl_t                 ctl;
    logic signed [PW-1:0] num_a, den_a, num_b, den_b;
    logic [QW-1:0]        qa, qb;
    geo_t                 geo_dly_reg [0:GEO_DLY-1];
    ctl_t                 ctl_dly_reg [0:DIV_LAT-1];

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[TOTAL_LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    ptd_front u_front (
        .clk    (clk),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .vert0_x(vert0_x),
        .vert0_y(vert0_y),
        .vert0_z(vert0_z),
        .vert1_x(vert1_x),
        .vert1_y(vert1_y),
        .vert1_z(vert1_z),
        .vert2_x(vert2_x),
        .vert2_y(vert2_y),
        .vert2_z(vert2_z),
        .geo    (geo),
        .ctl    (ctl),
        .num_a  (num_a),
        .den_a  (den_a),
        .num_b  (num_b),
        .den_b  (den_b)
    );

    ptd_div u_div_a (.clk(clk), .num(num_a), .den(den_a), .quo(qa));
    ptd_div u_div_b (.clk(clk), .num(num_b), .den(den_b), .quo(qb));

    // geometry and selection ride alongside the dividers
    always_ff @(posedge clk)
    begin
        geo_dly_reg[0] <= geo;
        for (int i = 1; i < GEO_DLY; i++)
            geo_dly_reg[i] <= geo_dly_reg[i-1];
        ctl_dly_reg[0] <= ctl;
        for (int i = 1; i < DIV_LAT; i++)
            ctl_dly_reg[i] <= ctl_dly_reg[i-1];
    end

    ptd_back u_back (
        .clk       (clk),
        .geo       (geo_dly_reg[GEO_DLY-1]),
        .ctl       (ctl_dly_reg[DIV_LAT-1]),
        .qa        (qa),
        .qb        (qb),
        .dist_sq   (dist_sq),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z),
        .feature   (feature),
        .param_s   (param_s),
        .param_t   (param_t),
        .degenerate(degenerate)
    );

    assign done = valid_reg[TOTAL_LAT-1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##TOTAL_LAT done)
        else $error("result beat missing after pipeline latency");

    a_feat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> feature <= FEAT_IN)
        else $error("feature code out of range");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> feature == FEAT_V0 && param_s == '0 && param_t == '0)
        else $error("degenerate result not at vertex 0");

    a_vert1: assert property (@(posedge clk) disable iff (!rst_n)
        done && feature == FEAT_V1 |-> param_s == PARAM_ONE && param_t == '0)
        else $error("vertex 1 result with wrong parameters");

    a_vert2: assert property (@(posedge clk) disable iff (!rst_n)
        done && feature == FEAT_V2 |-> param_s == '0 && param_t == PARAM_ONE)
        else $error("vertex 2 result with wrong parameters");

endmodule
`default_nettype wire

### verif/tb_point_triangle_distance.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_point_triangle_distance
// self-checking bench for the point to triangle distance pipeline: a queue
// driven source feeds query beats with random gaps, an exact-integer
// predictor computes the region, parameters, closest point and squared
// distance, and a monitor compares every result beat in order
// ============================================================================
module tb_point_triangle_distance;
    import ptd_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        coord_t c [12];
    } query_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        coord_t            nx;
        coord_t            ny;
        coord_t            nz;
        logic [2:0]        feat;
        logic [QW-1:0]     s;
        logic [QW-1:0]     t;
        logic              degen;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    coord_t            pin [12];
    logic              done;
    logic [DIST_W-1:0] dist_sq;
    coord_t            near_x;
    coord_t            near_y;
    coord_t            near_z;
    logic [2:0]        feature;
    logic [QW-1:0]     param_s;
    logic [QW-1:0]     param_t;
    logic              degenerate;

    query_t  pending_q [$];
    answer_t answer_q [$];
    query_t  cur_query;
    int      gap_left;
    int      err_count;
    bit      burst_mode;

    point_triangle_distance DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(pin[0]), .point_y(pin[1]), .point_z(pin[2]),
        .vert0_x(pin[3]), .vert0_y(pin[4]), .vert0_z(pin[5]),
        .vert1_x(pin[6]), .vert1_y(pin[7]), .vert1_z(pin[8]),
        .vert2_x(pin[9]), .vert2_y(pin[10]), .vert2_z(pin[11]),
        .done(done), .dist_sq(dist_sq), .near_x(near_x), .near_y(near_y),
        .near_z(near_z), .feature(feature), .param_s(param_s),
        .param_t(param_t), .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic wide_t dot3(input wide_t x [3], input wide_t y [3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic logic [QW-1:0] ratio_q(input wide_t num, input wide_t den);
        logic [QW-1:0] q;
        wide_t         r;
        q = '0;
        r = num;
        if (num <= 0)
            return '0;
        if (num >= den)
            return PARAM_ONE;
        for (int i = 0; i < PARAM_BITS; i++)
        begin
            r = r + r;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        if (r + r >= den)
            q = q + 1'b1;
        return q;
    endfunction

    function automatic logic [2:0] edge_clamp(input wide_t b, input wide_t a,
                                             input logic [2:0] f_end,
                                             input logic [2:0] f_edge,
                                             output logic [QW-1:0] p);
        if (b >= 0)
        begin
            p = '0;
            return FEAT_V0;
        end
        if (-b >= a)
        begin
            p = PARAM_ONE;
            return f_end;
        end
        p = ratio_q(-b, a);
        return f_edge;
    endfunction

    function automatic answer_t closest_feature(input query_t q);
        answer_t       r;
        wide_t         d [3];
        wide_t         e0 [3];
        wide_t         e1 [3];
        wide_t         w [3];
        wide_t         a00, a01, a11, b0, b1, det, sn, tn, den;
        wide_t         tmp0, tmp1, num, off, n, dist_w;
        logic [QW-1:0] s, t;
        logic [2:0]    feat;
        logic          degen;
        s = '0;
        t = '0;
        feat = FEAT_V0;
        degen = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            d[k]  = wide_t'(q.c[3+k]) - wide_t'(q.c[k]);
            e0[k] = wide_t'(q.c[6+k]) - wide_t'(q.c[3+k]);
            e1[k] = wide_t'(q.c[9+k]) - wide_t'(q.c[3+k]);
        end
        a00 = dot3(e0, e0);
        a01 = dot3(e0, e1);
        a11 = dot3(e1, e1);
        b0  = dot3(d, e0);
        b1  = dot3(d, e1);
        det = a00 * a11 - a01 * a01;
        if (det < 0)
            det = -det;
        sn  = a01 * b1 - a11 * b0;
        tn  = a01 * b0 - a00 * b1;
        den = a00 - (a01 + a01) + a11;
        if (sn + tn <= det)
        begin
            if (sn < 0)
            begin
                if (tn < 0 && b0 < 0)
                    feat = edge_clamp(b0, a00, FEAT_V1, FEAT_E01, s);
                else
                    feat = edge_clamp(b1, a11, FEAT_V2, FEAT_E20, t);
            end
            else if (tn < 0)
                feat = edge_clamp(b0, a00, FEAT_V1, FEAT_E01, s);
            else if (det == 0)
                degen = 1'b1;
            else
            begin
                feat = FEAT_IN;
                s = ratio_q(sn, det);
                t = ratio_q(tn, det);
            end
        end
        else if (sn < 0)
        begin
            tmp0 = a01 + b0;
            tmp1 = a11 + b1;
            if (tmp1 > tmp0)
            begin
                num = tmp1 - tmp0;
                if (num >= den)
                begin
                    feat = FEAT_V1;
                    s = PARAM_ONE;
                end
                else
                begin
                    feat = FEAT_E12;
                    s = ratio_q(num, den);
                    t = PARAM_ONE - s;
                end
            end
            else if (tmp1 <= 0)
            begin
                feat = FEAT_V2;
                t = PARAM_ONE;
            end
            else
                feat = edge_clamp(b1, a11, FEAT_V2, FEAT_E20, t);
        end
        else if (tn < 0)
        begin
            tmp0 = a01 + b1;
            tmp1 = a00 + b0;
            if (tmp1 > tmp0)
            begin
                num = tmp1 - tmp0;
                if (num >= den)
                begin
                    feat = FEAT_V2;
                    t = PARAM_ONE;
                end
                else
                begin
                    feat = FEAT_E12;
                    t = ratio_q(num, den);
                    s = PARAM_ONE - t;
                end
            end
            else if (tmp1 <= 0)
            begin
                feat = FEAT_V1;
                s = PARAM_ONE;
            end
            else
                feat = edge_clamp(b0, a00, FEAT_V1, FEAT_E01, s);
        end
        else
        begin
            num = (a11 + b1) - (a01 + b0);
            if (num <= 0)
            begin
                feat = FEAT_V2;
                t = PARAM_ONE;
            end
            else if (num >= den)
            begin
                feat = FEAT_V1;
                s = PARAM_ONE;
            end
            else
            begin
                feat = FEAT_E12;
                s = ratio_q(num, den);
                t = PARAM_ONE - s;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            off  = wide_t'(s) * e0[k] + wide_t'(t) * e1[k];
            w[k] = d[k] * wide_t'(PARAM_ONE) + off;
            off  = (off + (wide_t'(1) << (PARAM_BITS - 1))) >>> PARAM_BITS;
            n    = wide_t'(q.c[3+k]) + off;
            if (n > 8388607)
                n = 8388607;
            if (n < -8388608)
                n = -8388608;
            if (k == 0)
                r.nx = n[COORD_W-1:0];
            else if (k == 1)
                r.ny = n[COORD_W-1:0];
            else
                r.nz = n[COORD_W-1:0];
        end
        dist_w = (dot3(w, w) + (wide_t'(1) << (2 * PARAM_BITS - 1))) >>> (2 * PARAM_BITS);
        if (dist_w < 0)
            dist_w = 0;
        if (dist_w > (wide_t'(1) << DIST_W) - 1)
            dist_w = (wide_t'(1) << DIST_W) - 1;
        r.dist_val = dist_w[DIST_W-1:0];
        r.feat     = feat;
        r.s        = s;
        r.t        = t;
        r.degen    = degen;
        return r;
    endfunction

    function automatic query_t make_query(input int px, py, pz, ax, ay, az,
                                          input int bx, by, bz, cx, cy, cz);
        query_t q;
        q.c[0] = px; q.c[1] = py; q.c[2] = pz;
        q.c[3] = ax; q.c[4] = ay; q.c[5] = az;
        q.c[6] = bx; q.c[7] = by; q.c[8] = bz;
        q.c[9] = cx; q.c[10] = cy; q.c[11] = cz;
        return q;
    endfunction

    function automatic int rnd_coord(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     kind;
        int     span;
        kind = $urandom_range(0, 9);
        span = (kind < 5) ? 32768 : 2000000;
        for (int k = 0; k < 12; k++)
            q.c[k] = rnd_coord(span);
        if (kind == 6)
            for (int k = 0; k < 12; k++)
                q.c[k] = $urandom;
        else if (kind == 7)
        begin
            for (int k = 0; k < 3; k++)
                q.c[6+k] = ($urandom_range(0, 1)) ? q.c[3+k] : q.c[9+k];
        end
        else if (kind == 8)
        begin
            for (int k = 0; k < 3; k++)
                q.c[9+k] = q.c[3+k] + 2 * (q.c[6+k] - q.c[3+k]);
        end
        else if (kind == 9)
        begin
            for (int k = 0; k < 3; k++)
                q.c[k] = (q.c[3+k] + q.c[6+k] + q.c[9+k]) / 3 + rnd_coord(4096);
        end
        return q;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // accepted beats become expectations
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            answer_q.push_back(closest_feature(cur_query));
    end

    // driver, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur_query = pending_q.pop_front();
                for (int k = 0; k < 12; k++)
                    pin[k] <= cur_query.c[k];
                start <= 1'b1;
                gap_left <= next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                $display("mismatch: result beat with nothing expected");
                err_count++;
            end
            else
            begin
                a = answer_q.pop_front();
                if (dist_sq !== a.dist_val)
                    report_mismatch("dist_sq", dist_sq, a.dist_val);
                if (near_x !== a.nx)
                    report_mismatch("near_x", near_x, a.nx);
                if (near_y !== a.ny)
                    report_mismatch("near_y", near_y, a.ny);
                if (near_z !== a.nz)
                    report_mismatch("near_z", near_z, a.nz);
                if (feature !== a.feat)
                    report_mismatch("feature", feature, a.feat);
                if (param_s !== a.s)
                    report_mismatch("param_s", param_s, a.s);
                if (param_t !== a.t)
                    report_mismatch("param_t", param_t, a.t);
                if (degenerate !== a.degen)
                    report_mismatch("degenerate", degenerate, a.degen);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        start = 1'b0;
        for (int k = 0; k < 12; k++)
            pin[k] = '0;
        gap_left = 0;
        err_count = 0;
        burst_mode = 1'b0;
        rst_n = 1'b0;
        // directed: right triangle with legs of 4096 in the xy plane, then degenerate triangles and extremes
        pending_q.push_back(make_query(1000, 1000, 500, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(-1000, -1000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(8000, -100, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(-100, 8000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(2000, -1000, 7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(-1000, 2000, -7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(3000, 3000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(9000, 100, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(100, 9000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(6000, 6000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(1365, 1365, 1, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_query(5, 6, 7, 1, 1, 1, 2, 2, 2, 3, 3, 3));
        pending_q.push_back(make_query(5, 6, 7, 9, 9, 9, 9, 9, 9, 1, 2, 3));
        pending_q.push_back(make_query(8388607, 8388607, 8388607, -8388608, -8388608,
                                       -8388608, -8388608, 8388607, -8388608,
                                       8388607, -8388608, -8388608));
        pending_q.push_back(make_query(-8388608, -8388608, -8388608, 8388607, 8388607,
                                       8388607, 8388607, -8388608, 8388607,
                                       -8388608, 8388607, 8388607));
        pending_q.push_back(make_query(8388607, -8388608, 8388607, -8388608, -8388608,
                                       -8388608, 8388607, 8388607, 8388607,
                                       -8388608, 8388607, -8388608));
        pending_q.push_back(make_query(-8388608, -8388608, -8388608, -8388608,
                                       -8388608, -8388608, -8388608, -8388608,
                                       -8388608, -8388608, -8388608, -8388608));
        pending_q.push_back(make_query(8388607, 8388607, 8388607, 8388607, 8388607,
                                       8388607, 8388607, 8388607, 8388607,
                                       8388607, 8388607, 8388607));
        pending_q.push_back(make_query(0, 0, 8388607, -8388608, -8388608, 0,
                                       8388607, -8388608, 0, 0, 8388607, 0));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 700; i++)
        begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            pending_q.push_back(random_query());
            while (pending_q.size() > 8)
                @(posedge clk);
        end
        while (pending_q.size() > 0 || start)
            @(posedge clk);
        while (answer_q.size() > 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 8) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
